[rtl/core/plarb_pkg.sv]
package plarb_pkg;

	// Sizes of the lock state
	localparam int PRIO_LEVELS = 16;
	localparam int COUNT_MAX   = 255;
	localparam int PRIO_W      = $clog2(PRIO_LEVELS);
	localparam int LEV_W       = 5;
	localparam int CNT_W       = $clog2(COUNT_MAX + 1);

	// Request modes
	localparam logic [1:0] MODE_LOCK   = 2'd0;
	localparam logic [1:0] MODE_UNLOCK = 2'd1;
	localparam logic [1:0] MODE_TRY    = 2'd2;

	// Result status codes
	localparam logic [2:0] ST_GRANTED  = 3'd0;
	localparam logic [2:0] ST_QUEUED   = 3'd1;
	localparam logic [2:0] ST_BUSY     = 3'd2;
	localparam logic [2:0] ST_FREED    = 3'd3;
	localparam logic [2:0] ST_HANDOVER = 3'd4;
	localparam logic [2:0] ST_ERROR    = 3'd5;

	typedef struct packed {
		logic [1:0] mode;
		logic [3:0] priority_req;
	} in_item_t;

	typedef struct packed {
		logic [2:0] status;
		logic [3:0] grant_priority;
		logic       held;
	} out_item_t;

	// Controller to datapath commands
	typedef struct packed {
		logic load;
		logic exec;
	} plarb_cmd_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_EXEC,
		S_RESP
	} plarb_state_t;

endpackage

[rtl/core/plarb_ctrl.sv]
module plarb_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	output logic                 out_valid,
	input  logic                 out_ready,
	output plarb_pkg::plarb_cmd_t cmd
);
	import plarb_pkg::*;

	plarb_state_t state_q, state_d;

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state and commands
	always_comb begin
		state_d   = state_q;
		in_ready  = 1'b0;
		out_valid = 1'b0;
		cmd       = '0;
		unique case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = S_EXEC;
				end
			end
			S_EXEC: begin
				cmd.exec = 1'b1;
				state_d  = S_RESP;
			end
			S_RESP: begin
				out_valid = 1'b1;
				// result transfer frees the slot; a new request may enter at once
				in_ready  = out_ready;
				if (out_ready) begin
					if (in_valid) begin
						cmd.load = 1'b1;
						state_d  = S_EXEC;
					end else begin
						state_d  = S_IDLE;
					end
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

endmodule

[rtl/core/plarb_dp.sv]
module plarb_dp (
	input  logic                  clk,
	input  logic                  arst_n,
	input  plarb_pkg::plarb_cmd_t cmd,
	input  plarb_pkg::in_item_t   in_data,
	input  logic                  cfg_valid,
	input  logic [4:0]            cfg_data,
	output plarb_pkg::out_item_t  out_data
);
	import plarb_pkg::*;

	in_item_t          op_q;
	out_item_t         res_q;
	logic [LEV_W-1:0]  levels_q;
	logic              held_q;
	logic [CNT_W-1:0]  cnt_q [PRIO_LEVELS];

	logic [LEV_W-1:0]  eff_lev;
	logic              found;
	logic [PRIO_W-1:0] found_p;
	logic [PRIO_W-1:0] sel;
	logic [CNT_W-1:0]  cnt_rd;
	logic              cnt_we;
	logic              cnt_inc;
	logic [CNT_W-1:0]  cnt_wd;
	logic              held_d;
	out_item_t         res_d;

	// Clamp level count to 1 .. PRIO_LEVELS
	always_comb begin
		priority if (levels_q == '0) begin
			eff_lev = LEV_W'(1);
		end else if (levels_q > LEV_W'(PRIO_LEVELS)) begin
			eff_lev = LEV_W'(PRIO_LEVELS);
		end else begin
			eff_lev = levels_q;
		end
	end

	// Highest level in use with waiters
	always_comb begin
		found   = 1'b0;
		found_p = '0;
		for (int i = 0; i < PRIO_LEVELS; i++) begin
			if (cnt_q[i] != '0 && LEV_W'(i) < eff_lev) begin
				found   = 1'b1;
				found_p = PRIO_W'(i);
			end
		end
	end

	// One count read per request
	assign sel    = (op_q.mode == MODE_UNLOCK) ? found_p : op_q.priority_req;
	assign cnt_rd = cnt_q[sel];
	assign cnt_wd = cnt_inc ? cnt_rd + CNT_W'(1) : cnt_rd - CNT_W'(1);

	// Request decode
	always_comb begin
		held_d  = held_q;
		cnt_we  = 1'b0;
		cnt_inc = 1'b0;
		res_d   = '{status: ST_ERROR, grant_priority: '0, held: 1'b0};
		unique case (op_q.mode)
			MODE_LOCK: begin
				priority if ({1'b0, op_q.priority_req} >= eff_lev) begin
					res_d.status = ST_ERROR;
				end else if (!held_q) begin
					held_d       = 1'b1;
					res_d.status = ST_GRANTED;
				end else if (cnt_rd == CNT_W'(COUNT_MAX)) begin
					res_d.status = ST_ERROR;
				end else begin
					cnt_we       = 1'b1;
					cnt_inc      = 1'b1;
					res_d.status = ST_QUEUED;
				end
			end
			MODE_UNLOCK: begin
				if (found) begin
					cnt_we               = 1'b1;
					held_d               = 1'b1;
					res_d.status         = ST_HANDOVER;
					res_d.grant_priority = found_p;
				end else begin
					held_d       = 1'b0;
					res_d.status = ST_FREED;
				end
			end
			MODE_TRY: begin
				if (held_q) begin
					res_d.status = ST_BUSY;
				end else begin
					held_d       = 1'b1;
					res_d.status = ST_GRANTED;
				end
			end
			default: res_d.status = ST_ERROR;
		endcase
		res_d.held = held_d;
	end

	// Control state: level register, held flag, waiter counts
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			levels_q <= LEV_W'(PRIO_LEVELS);
			held_q   <= 1'b0;
			for (int i = 0; i < PRIO_LEVELS; i++) begin
				cnt_q[i] <= '0;
			end
		end else begin
			if (cfg_valid) begin
				levels_q <= cfg_data;
			end
			if (cmd.exec) begin
				held_q <= held_d;
				if (cnt_we) begin
					cnt_q[sel] <= cnt_wd;
				end
			end
		end
	end

	// Request and result payload registers
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q <= in_data;
		end
		if (cmd.exec) begin
			res_q <= res_d;
		end
	end

	assign out_data = res_q;

endmodule

[rtl/core/priority_lock_arbiter_unit.sv]
// Priority lock arbiter.
// Request channel (in_valid/in_ready/in_data): mode is lock, unlock or
// trylock; priority_req applies to lock only. Every request produces one
// result on the out channel (out_valid/out_ready/out_data) with status,
// grant_priority and the held flag after the request.
// Config channel (cfg_valid/cfg_ready/cfg_data) writes levels_in_use; it is
// always ready and must only be written while no request is in flight.
// Request flow: a transferred request is registered by the load step, its
// result is computed and registered by the execute step, then offered.
// A new request is not taken until the result transfers, set by the
// load/execute sequence of the controller; the next request is taken in
// the same cycle the result transfers.
// Reset: lock free, all waiter counts zero, levels_in_use = 16.
// Receiver stall: the result is held in its register and in_ready stays low
// until the result transfers.
module priority_lock_arbiter_unit (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  plarb_pkg::in_item_t  in_data,
	output logic                 out_valid,
	input  logic                 out_ready,
	output plarb_pkg::out_item_t out_data,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [4:0]           cfg_data
);
	import plarb_pkg::*;

	plarb_cmd_t cmd;

	assign cfg_ready = 1'b1;

	// Sequencer
	plarb_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.cmd       (cmd)
	);

	// Lock state and decision logic
	plarb_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.in_data   (in_data),
		.cfg_valid (cfg_valid),
		.cfg_data  (cfg_data),
		.out_data  (out_data)
	);

endmodule

[dv/tb.sv]
`timescale 1ns / 1ps

module tb;
	import plarb_pkg::*;

	localparam logic [1:0] MODE_SPARE   = 2'd3;
	localparam int         CYCLE_LIMIT  = 400000;
	localparam int         HOLD_CYCLES  = 300;
	localparam int         PHASE_ITEMS  = 115;
	localparam int         MAX_PRINTS   = 40;

	typedef enum bit {ROW_REQ, ROW_CFG} row_kind_t;

	// One line of the directed table: a request or a levels write
	typedef struct packed {
		row_kind_t  kind;
		logic [1:0] mode;
		logic [3:0] prio;
		logic [4:0] levels;
		logic       typed;
		out_item_t  want;
	} dir_row_t;

	logic       clk;
	logic       arst_n;
	logic       in_valid;
	logic       in_ready;
	in_item_t   in_data;
	logic       out_valid;
	logic       out_ready;
	out_item_t  out_data;
	logic       cfg_valid;
	logic       cfg_ready;
	logic [4:0] cfg_data;

	// Lock state as the block should hold it
	logic             lock_taken;
	logic [CNT_W-1:0] waiters [PRIO_LEVELS];
	logic [LEV_W-1:0] level_reg;

	out_item_t   pending_results [$];
	int unsigned mismatches;
	int unsigned cycle_count;
	int unsigned send_idle_pct;
	int unsigned stall_pct;
	int unsigned hold_requests;
	int unsigned holds_served;
	int unsigned hold_left;
	out_item_t   oldest;

	// Requests and levels writes; typed rows carry their expected result
	dir_row_t directed_rows [23] = '{
		'{ROW_REQ, MODE_UNLOCK, 4'd0,  5'd0,  1'b1, '{ST_FREED,    4'd0,  1'b0}},
		'{ROW_REQ, MODE_TRY,    4'd0,  5'd0,  1'b1, '{ST_GRANTED,  4'd0,  1'b1}},
		'{ROW_REQ, MODE_TRY,    4'd15, 5'd0,  1'b1, '{ST_BUSY,     4'd0,  1'b1}},
		'{ROW_REQ, MODE_LOCK,   4'd15, 5'd0,  1'b1, '{ST_QUEUED,   4'd0,  1'b1}},
		'{ROW_REQ, MODE_LOCK,   4'd0,  5'd0,  1'b1, '{ST_QUEUED,   4'd0,  1'b1}},
		'{ROW_REQ, MODE_LOCK,   4'd7,  5'd0,  1'b0, '{ST_GRANTED,  4'd0,  1'b0}},
		'{ROW_REQ, MODE_SPARE,  4'd15, 5'd0,  1'b1, '{ST_ERROR,    4'd0,  1'b1}},
		'{ROW_REQ, MODE_UNLOCK, 4'd0,  5'd0,  1'b1, '{ST_HANDOVER, 4'd15, 1'b1}},
		'{ROW_REQ, MODE_UNLOCK, 4'd9,  5'd0,  1'b0, '{ST_GRANTED,  4'd0,  1'b0}},
		'{ROW_REQ, MODE_UNLOCK, 4'd6,  5'd0,  1'b0, '{ST_GRANTED,  4'd0,  1'b0}},
		'{ROW_REQ, MODE_UNLOCK, 4'd0,  5'd0,  1'b1, '{ST_FREED,    4'd0,  1'b0}},
		'{ROW_REQ, MODE_LOCK,   4'd10, 5'd0,  1'b1, '{ST_GRANTED,  4'd0,  1'b1}},
		'{ROW_REQ, MODE_LOCK,   4'd5,  5'd0,  1'b0, '{ST_GRANTED,  4'd0,  1'b0}},
		'{ROW_CFG, MODE_LOCK,   4'd0,  5'd0,  1'b0, '{ST_GRANTED,  4'd0,  1'b0}},
		'{ROW_REQ, MODE_LOCK,   4'd1,  5'd0,  1'b1, '{ST_ERROR,    4'd0,  1'b1}},
		'{ROW_REQ, MODE_LOCK,   4'd0,  5'd0,  1'b0, '{ST_GRANTED,  4'd0,  1'b0}},
		'{ROW_REQ, MODE_UNLOCK, 4'd0,  5'd0,  1'b0, '{ST_GRANTED,  4'd0,  1'b0}},
		'{ROW_REQ, MODE_UNLOCK, 4'd0,  5'd0,  1'b1, '{ST_FREED,    4'd0,  1'b0}},
		'{ROW_CFG, MODE_LOCK,   4'd0,  5'd31, 1'b0, '{ST_GRANTED,  4'd0,  1'b0}},
		'{ROW_REQ, MODE_LOCK,   4'd15, 5'd0,  1'b1, '{ST_GRANTED,  4'd0,  1'b1}},
		'{ROW_REQ, MODE_UNLOCK, 4'd0,  5'd0,  1'b1, '{ST_HANDOVER, 4'd5,  1'b1}},
		'{ROW_REQ, MODE_UNLOCK, 4'd0,  5'd0,  1'b1, '{ST_FREED,    4'd0,  1'b0}},
		'{ROW_CFG, MODE_LOCK,   4'd0,  5'd16, 1'b0, '{ST_GRANTED,  4'd0,  1'b0}}
	};

	logic [4:0] phase_levels [8] = '{5'd16, 5'd1, 5'd31, 5'd0, 5'd0, 5'd9, 5'd0, 5'd16};

	priority_lock_arbiter_unit i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// Register value 0 behaves as one level, anything past the array as all of them
	function automatic int effective_levels();
		if (level_reg == 0)
			return 1;
		if (level_reg > PRIO_LEVELS)
			return PRIO_LEVELS;
		return int'(level_reg);
	endfunction

	// Apply one request to the lock state and return the result it produces
	function automatic out_item_t arbitrate(input in_item_t req);
		out_item_t res;
		int        eff;
		bit        found;
		res   = '0;
		res.status = ST_ERROR;
		eff   = effective_levels();
		found = 1'b0;
		case (req.mode)
			MODE_LOCK: begin
				if (int'(req.priority_req) >= eff)
					res.status = ST_ERROR;
				else if (!lock_taken) begin
					lock_taken = 1'b1;
					res.status = ST_GRANTED;
				end else if (waiters[req.priority_req] >= COUNT_MAX)
					res.status = ST_ERROR;
				else begin
					waiters[req.priority_req] = waiters[req.priority_req] + 1'b1;
					res.status = ST_QUEUED;
				end
			end
			MODE_UNLOCK: begin
				// highest waiting level within the active range takes the lock
				for (int p = eff - 1; p >= 0; p--) begin
					if (!found && waiters[p] != 0) begin
						found = 1'b1;
						waiters[p] = waiters[p] - 1'b1;
						res.grant_priority = p[3:0];
					end
				end
				lock_taken = found;
				res.status = found ? ST_HANDOVER : ST_FREED;
			end
			MODE_TRY: begin
				if (lock_taken)
					res.status = ST_BUSY;
				else begin
					lock_taken = 1'b1;
					res.status = ST_GRANTED;
				end
			end
			default: res.status = ST_ERROR;
		endcase
		res.held = lock_taken;
		return res;
	endfunction

	task automatic report_mismatch(input string what, input int unsigned want,
			input int unsigned got);
		if (mismatches < MAX_PRINTS)
			$display("mismatch on %s: expected %0d, got %0d (cycle %0d)",
				what, want, got, cycle_count);
		mismatches++;
	endtask

	// Offer one request, hold it until the transfer, then log what should come back
	task automatic send_request(input in_item_t req, input bit typed, input out_item_t want);
		out_item_t got;
		@(negedge clk);
		while ($urandom_range(99, 0) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		in_data  <= req;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		got = arbitrate(req);
		pending_results.push_back(typed ? want : got);
	endtask

	task automatic wait_drained();
		@(negedge clk);
		in_valid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
	endtask

	// Levels writes only happen with nothing in flight
	task automatic write_levels(input logic [4:0] value);
		wait_drained();
		repeat (3) @(negedge clk);
		cfg_valid <= 1'b1;
		cfg_data  <= value;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		level_reg = value;
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// Result checker
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			if (pending_results.size() == 0)
				report_mismatch("unexpected result status", 0, out_data.status);
			else begin
				oldest = pending_results.pop_front();
				if (out_data.status !== oldest.status)
					report_mismatch("status", oldest.status, out_data.status);
				if (out_data.grant_priority !== oldest.grant_priority)
					report_mismatch("grant_priority", oldest.grant_priority,
						out_data.grant_priority);
				if (out_data.held !== oldest.held)
					report_mismatch("held", oldest.held, out_data.held);
			end
		end
	end

	// Receiver: random stalls, plus long hold-offs on request
	initial begin
		out_ready    = 1'b0;
		holds_served = 0;
		hold_left    = 0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (hold_requests != holds_served) begin
				holds_served++;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				out_ready <= 1'b0;
			end else
				out_ready <= ($urandom_range(99, 0) >= stall_pct);
		end
	end

	// Watchdog
	initial begin
		cycle_count = 0;
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("*** FAILED ***");
		$finish;
	end

	initial begin
		in_item_t    req;
		logic [3:0]  fill_prio;
		logic [4:0]  lev;
		int          eff;
		int unsigned roll;

		arst_n        = 1'b0;
		in_valid      = 1'b0;
		in_data       = '0;
		cfg_valid     = 1'b0;
		cfg_data      = '0;
		send_idle_pct = 0;
		stall_pct     = 0;
		hold_requests = 0;
		mismatches    = 0;
		lock_taken    = 1'b0;
		level_reg     = 5'd16;
		for (int i = 0; i < PRIO_LEVELS; i++)
			waiters[i] = '0;
		repeat (5) @(negedge clk);
		arst_n = 1'b1;

		// Directed table
		foreach (directed_rows[i]) begin
			if (directed_rows[i].kind == ROW_CFG)
				write_levels(directed_rows[i].levels);
			else begin
				req.mode         = directed_rows[i].mode;
				req.priority_req = directed_rows[i].prio;
				send_request(req, directed_rows[i].typed, directed_rows[i].want);
			end
		end

		// Random phases over several level settings and idle patterns
		for (int phase = 0; phase < 8; phase++) begin
			lev = (phase == 4 || phase == 6) ? 5'($urandom_range(31, 0)) : phase_levels[phase];
			write_levels(lev);
			case (phase % 4)
				0: begin send_idle_pct = 0;  stall_pct = 0;  end
				1: begin send_idle_pct = 47; stall_pct = 0;  end
				2: begin send_idle_pct = 0;  stall_pct = 47; end
				default: begin send_idle_pct = 10; stall_pct = 10; end
			endcase
			// long receiver hold-off while requests keep coming
			if (phase == 0 || phase == 5)
				hold_requests++;
			eff = effective_levels();
			for (int n = 0; n < PHASE_ITEMS; n++) begin
				roll = $urandom_range(99, 0);
				if (roll < 45)
					req.mode = MODE_LOCK;
				else if (roll < 80)
					req.mode = MODE_UNLOCK;
				else if (roll < 95)
					req.mode = MODE_TRY;
				else
					req.mode = MODE_SPARE;
				if ($urandom_range(99, 0) < 85)
					req.priority_req = 4'($urandom_range(eff - 1, 0));
				else
					req.priority_req = 4'($urandom_range(15, 0));
				send_request(req, 1'b0, '0);
				// occasional sender pause until everything is back
				if ($urandom_range(59, 0) == 0 || n == PHASE_ITEMS / 2)
					wait_drained();
			end

			// Saturate one waiter counter, then unlock it back down
			if (phase == 3) begin
				write_levels(5'd16);
				fill_prio        = 4'($urandom_range(15, 0));
				req.mode         = MODE_TRY;
				req.priority_req = 4'($urandom_range(15, 0));
				send_request(req, 1'b0, '0);
				req.mode         = MODE_LOCK;
				req.priority_req = fill_prio;
				repeat (COUNT_MAX + 2) send_request(req, 1'b0, '0);
				req.mode = MODE_UNLOCK;
				repeat (COUNT_MAX + 4) begin
					req.priority_req = 4'($urandom_range(15, 0));
					send_request(req, 1'b0, '0);
				end
			end
		end

		wait_drained();
		repeat (10) @(posedge clk);
		if (mismatches == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule

[files.f]
rtl/core/plarb_pkg.sv
rtl/core/plarb_ctrl.sv
rtl/core/plarb_dp.sv
rtl/core/priority_lock_arbiter_unit.sv
dv/tb.sv
